// ----- rtl/psfe_pkg.sv -----
`default_nettype none
package psfe_pkg;

   localparam int NUM_W         = 40;
   localparam int LIMIT_W       = 20;
   localparam int DIV_W         = 13;
   localparam int POW_W         = 6;
   localparam int RSP_DATA_W    = 56;
   localparam int SIEVE_SIZE_DEF  = 1048576;
   localparam int PRIME_SLOTS_DEF = 131072;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1048574;
   localparam logic [DIV_W-1:0]   DIV_MAX     = 13'd8191;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_CROSS,
      ST_F_START,
      ST_F_RD,
      ST_F_LOAD,
      ST_F_SQ,
      ST_F_CMP,
      ST_F_DIVGO,
      ST_F_DIV,
      ST_F_DIVCHK,
      ST_F_PUSH,
      ST_FIN_PUSH,
      ST_FIN_LAST,
      ST_TRIVIAL
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/psfe_ram.sv -----
`default_nettype none
module psfe_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/prime_sieve_factor_engine.sv -----
// Prime sieve and factorization engine.
// Input channel (req_): one item is a 40-bit number. Result channel (rsp_):
// the prime factors of the number in ascending order with multiplicity, one
// item per factor; the final item has rsp_tlast set and carries the primality
// bit, the saturating divisor count and the beyond_range flag. Numbers zero
// and one give a single item with rsp_tuser (factor valid) low.
// The first item after reset or after a csr_we write first builds the sieve:
// a fill sweep over indices 0 to limit+1, a scan that reads each index from
// 2 up, and one write per crossed-out multiple of each prime found.
// A query then walks the stored prime list: each prime is fetched, squared
// and compared with the remainder, and the 40-bit remainder is divided by a
// restoring divider that retires one quotient bit per cycle. A prime is
// divided again after each factor found; the walk ends at the first prime
// whose square exceeds the remainder, or at the end of the list.
// One item is processed at a time; req_tready is high only between queries.
// A result waits in the output register while rsp_tready is low, and the
// walk stalls only when it has a further result to hand over.
// Reset sets the limit to 1048574 and marks the sieve as not built; the
// sieve and prime memories are not cleared, the build writes them.
`default_nettype none
module prime_sieve_factor_engine #(
   parameter int SIEVE_SIZE  = psfe_pkg::SIEVE_SIZE_DEF,
   parameter int PRIME_SLOTS = psfe_pkg::PRIME_SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [psfe_pkg::NUM_W-1:0]        req_tdata,   // [39:0] number
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [39:0] factor, [40] is_prime, [53:41] divisor_count, [54] beyond_range
   output logic      [psfe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tuser,   // [0] factor_valid
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [psfe_pkg::LIMIT_W-1:0]      csr_wdata
);

   localparam int NW  = psfe_pkg::NUM_W;
   localparam int DW  = psfe_pkg::DIV_W;
   localparam int PWW = psfe_pkg::POW_W;
   localparam int AW  = $clog2(SIEVE_SIZE);
   localparam int PW  = $clog2(PRIME_SLOTS);
   localparam int TW  = PW + 1;
   localparam int CW  = ((AW > psfe_pkg::LIMIT_W) ? AW : psfe_pkg::LIMIT_W) + 1;
   localparam int MW  = ((2 * AW > NW) ? 2 * AW : NW) + 1;
   localparam int KW  = $clog2(NW);

   function automatic logic [DW-1:0] sat_mul(input logic [DW-1:0] a,
                                             input logic [PWW-1:0] b);
      logic [DW+PWW-1:0] prod;
      prod = (DW + PWW)'(a) * (DW + PWW)'(b);
      if (prod > (DW + PWW)'(psfe_pkg::DIV_MAX)) begin
         return psfe_pkg::DIV_MAX;
      end
      return prod[DW-1:0];
   endfunction

   psfe_pkg::state_type state_ff, state_in;

   logic [psfe_pkg::LIMIT_W-1:0] limit_ff;
   logic                         map_ready_ff;
   logic [NW-1:0]                num_ff;
   logic [NW-1:0]                rem_ff;
   logic [AW-1:0]                top_ff;
   logic [AW:0]                  i_ff;
   logic [AW:0]                  j_ff;
   logic [2*AW-1:0]              sq_ff;
   logic [TW-1:0]                total_ff;
   logic [TW-1:0]                idx_ff;
   logic [AW-1:0]                p_ff;
   logic [2*AW-1:0]              psq_ff;
   logic [DW-1:0]                divs_ff;
   logic [PWW-1:0]               pow_ff;
   logic [NW-1:0]                pend_ff;
   logic                         has_pend_ff;
   logic                         multi_ff;
   logic                         beyond_ff;
   logic [NW-1:0]                dvd_ff;
   logic [AW-1:0]                part_ff;
   logic [KW-1:0]                cnt_ff;

   logic                         rsp_valid_ff;
   logic [NW-1:0]                o_factor_ff;
   logic                         o_fv_ff;
   logic                         o_last_ff;
   logic                         o_prime_ff;
   logic [DW-1:0]                o_divs_ff;
   logic                         o_beyond_ff;

   // output-side and memory controls
   logic                         out_load;
   logic [NW-1:0]                o_factor_in;
   logic                         o_fv_in;
   logic                         o_last_in;
   logic                         o_prime_in;
   logic [DW-1:0]                o_divs_in;
   logic                         o_beyond_in;
   logic                         map_we;
   logic [AW-1:0]                map_waddr;
   logic                         map_wdata;
   logic [AW-1:0]                map_raddr;
   logic                         map_rdata;
   logic                         list_we;
   logic [PW-1:0]                list_waddr;
   logic [PW-1:0]                list_raddr;
   logic [AW-1:0]                list_rdata;

   logic                         req_acc;
   logic                         out_free;
   logic [CW-1:0]                lim_ext;
   logic [CW-1:0]                lim_eff;
   logic [AW:0]                  top_ext;
   logic [AW:0]                  j_next;
   logic                         i_at_top;
   logic [AW:0]                  div_shift;
   logic                         div_ge;
   logic [MW-1:0]                psq_ext;
   logic [MW-1:0]                rem_ext;

   assign req_tready = (state_ff == psfe_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign lim_ext  = CW'(limit_ff);
   always_comb begin
      lim_eff = lim_ext;
      if (lim_ext < CW'(2)) begin
         lim_eff = CW'(2);
      end else if (lim_ext > CW'(SIEVE_SIZE - 2)) begin
         lim_eff = CW'(SIEVE_SIZE - 2);
      end
   end

   assign top_ext   = {1'b0, top_ff};
   assign j_next    = j_ff + i_ff;
   assign i_at_top  = (i_ff == top_ext);
   assign div_shift = {part_ff, dvd_ff[NW-1]};
   assign div_ge    = (div_shift >= {1'b0, p_ff});
   assign psq_ext   = MW'(psq_ff);
   assign rem_ext   = MW'(rem_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psfe_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = map_ready_ff ? psfe_pkg::ST_F_START : psfe_pkg::ST_FILL;
            end
         end
         psfe_pkg::ST_FILL: begin
            if (i_at_top) state_in = psfe_pkg::ST_SCAN_RD;
         end
         psfe_pkg::ST_SCAN_RD: state_in = psfe_pkg::ST_SCAN_CHK;
         psfe_pkg::ST_SCAN_CHK: begin
            if (map_rdata && (sq_ff <= (2 * AW)'(top_ff))) begin
               state_in = psfe_pkg::ST_CROSS;
            end else if (i_at_top) begin
               state_in = psfe_pkg::ST_F_START;
            end else begin
               state_in = psfe_pkg::ST_SCAN_RD;
            end
         end
         psfe_pkg::ST_CROSS: begin
            if (j_next > top_ext) state_in = psfe_pkg::ST_SCAN_RD;
         end
         psfe_pkg::ST_F_START: begin
            state_in = (num_ff <= NW'(1)) ? psfe_pkg::ST_TRIVIAL : psfe_pkg::ST_F_RD;
         end
         psfe_pkg::ST_F_RD: begin
            state_in = (idx_ff >= total_ff) ? psfe_pkg::ST_FIN_PUSH : psfe_pkg::ST_F_LOAD;
         end
         psfe_pkg::ST_F_LOAD: state_in = psfe_pkg::ST_F_SQ;
         psfe_pkg::ST_F_SQ:   state_in = psfe_pkg::ST_F_CMP;
         psfe_pkg::ST_F_CMP: begin
            state_in = (psq_ext > rem_ext) ? psfe_pkg::ST_FIN_PUSH : psfe_pkg::ST_F_DIVGO;
         end
         psfe_pkg::ST_F_DIVGO: state_in = psfe_pkg::ST_F_DIV;
         psfe_pkg::ST_F_DIV: begin
            if (cnt_ff == KW'(NW - 1)) state_in = psfe_pkg::ST_F_DIVCHK;
         end
         psfe_pkg::ST_F_DIVCHK: begin
            state_in = (part_ff == '0) ? psfe_pkg::ST_F_PUSH : psfe_pkg::ST_F_RD;
         end
         psfe_pkg::ST_F_PUSH: begin
            if (!has_pend_ff || out_free) state_in = psfe_pkg::ST_F_DIVGO;
         end
         psfe_pkg::ST_FIN_PUSH: begin
            if (rem_ff == NW'(1) || !has_pend_ff || out_free) begin
               state_in = psfe_pkg::ST_FIN_LAST;
            end
         end
         psfe_pkg::ST_FIN_LAST: begin
            if (out_free) state_in = psfe_pkg::ST_IDLE;
         end
         psfe_pkg::ST_TRIVIAL: begin
            if (out_free) state_in = psfe_pkg::ST_IDLE;
         end
         default: state_in = psfe_pkg::ST_IDLE;
      endcase
   end

   // memory and result controls
   always_comb begin
      map_we      = 1'b0;
      map_waddr   = i_ff[AW-1:0];
      map_wdata   = 1'b0;
      map_raddr   = i_ff[AW-1:0];
      list_we     = 1'b0;
      list_waddr  = total_ff[PW-1:0];
      list_raddr  = idx_ff[PW-1:0];
      out_load    = 1'b0;
      o_factor_in = pend_ff;
      o_fv_in     = 1'b1;
      o_last_in   = 1'b0;
      o_prime_in  = 1'b0;
      o_divs_in   = '0;
      o_beyond_in = 1'b0;
      unique case (state_ff)
         psfe_pkg::ST_FILL: begin
            map_we    = 1'b1;
            map_wdata = (i_ff >= (AW + 1)'(2));
         end
         psfe_pkg::ST_SCAN_CHK: begin
            list_we = map_rdata && (total_ff < TW'(PRIME_SLOTS));
         end
         psfe_pkg::ST_CROSS: begin
            map_we    = 1'b1;
            map_waddr = j_ff[AW-1:0];
            map_wdata = 1'b0;
         end
         psfe_pkg::ST_F_PUSH: begin
            out_load = has_pend_ff && out_free;
         end
         psfe_pkg::ST_FIN_PUSH: begin
            out_load = (rem_ff != NW'(1)) && has_pend_ff && out_free;
         end
         psfe_pkg::ST_FIN_LAST: begin
            out_load    = out_free;
            o_last_in   = 1'b1;
            o_prime_in  = !multi_ff;
            o_divs_in   = divs_ff;
            o_beyond_in = beyond_ff;
         end
         psfe_pkg::ST_TRIVIAL: begin
            out_load    = out_free;
            o_factor_in = '0;
            o_fv_in     = 1'b0;
            o_last_in   = 1'b1;
            o_divs_in   = (num_ff == '0) ? DW'(0) : DW'(1);
         end
         default: begin
         end
      endcase
   end

   psfe_ram #(.WIDTH(1), .DEPTH(SIEVE_SIZE)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   psfe_ram #(.WIDTH(AW), .DEPTH(PRIME_SLOTS)) u_list (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_waddr),
      .wr_data (i_ff[AW-1:0]),
      .rd_addr (list_raddr),
      .rd_data (list_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psfe_pkg::ST_IDLE;
         limit_ff     <= psfe_pkg::LIMIT_RESET;
         map_ready_ff <= 1'b0;
         total_ff     <= '0;
         has_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            limit_ff     <= csr_wdata;
            map_ready_ff <= 1'b0;
         end else if (state_ff == psfe_pkg::ST_SCAN_CHK && state_in == psfe_pkg::ST_F_START) begin
            map_ready_ff <= 1'b1;
         end
         if (req_acc && !map_ready_ff) begin
            total_ff <= '0;
         end else if (list_we) begin
            total_ff <= total_ff + TW'(1);
         end
         if (state_ff == psfe_pkg::ST_F_START) begin
            has_pend_ff <= 1'b0;
         end else if ((state_ff == psfe_pkg::ST_F_PUSH && state_in == psfe_pkg::ST_F_DIVGO)
                      || (state_ff == psfe_pkg::ST_FIN_PUSH && rem_ff != NW'(1)
                          && state_in == psfe_pkg::ST_FIN_LAST)) begin
            has_pend_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (out_load) begin
         o_factor_ff <= o_factor_in;
         o_fv_ff     <= o_fv_in;
         o_last_ff   <= o_last_in;
         o_prime_ff  <= o_prime_in;
         o_divs_ff   <= o_divs_in;
         o_beyond_ff <= o_beyond_in;
      end
      unique case (state_ff)
         psfe_pkg::ST_IDLE: begin
            num_ff <= req_tdata;
            top_ff <= AW'(lim_eff + CW'(1));
            i_ff   <= '0;
         end
         psfe_pkg::ST_FILL: begin
            i_ff <= i_at_top ? (AW + 1)'(2) : i_ff + (AW + 1)'(1);
         end
         psfe_pkg::ST_SCAN_RD: begin
            sq_ff <= i_ff[AW-1:0] * i_ff[AW-1:0];
         end
         psfe_pkg::ST_SCAN_CHK: begin
            j_ff <= sq_ff[AW:0];
            if (!(map_rdata && (sq_ff <= (2 * AW)'(top_ff))) && !i_at_top) begin
               i_ff <= i_ff + (AW + 1)'(1);
            end
         end
         psfe_pkg::ST_CROSS: begin
            j_ff <= j_next;
            if (j_next > top_ext) i_ff <= i_ff + (AW + 1)'(1);
         end
         psfe_pkg::ST_F_START: begin
            rem_ff   <= num_ff;
            idx_ff   <= '0;
            divs_ff  <= DW'(1);
            pow_ff   <= '0;
            multi_ff <= 1'b0;
         end
         psfe_pkg::ST_F_RD: begin
            beyond_ff <= (rem_ff >= NW'(4));
         end
         psfe_pkg::ST_F_LOAD: p_ff <= list_rdata;
         psfe_pkg::ST_F_SQ:   psq_ff <= p_ff * p_ff;
         psfe_pkg::ST_F_CMP: begin
            beyond_ff <= 1'b0;
         end
         psfe_pkg::ST_F_DIVGO: begin
            dvd_ff  <= rem_ff;
            part_ff <= '0;
            cnt_ff  <= '0;
         end
         psfe_pkg::ST_F_DIV: begin
            dvd_ff  <= {dvd_ff[NW-2:0], div_ge};
            part_ff <= div_ge ? AW'(div_shift - {1'b0, p_ff}) : div_shift[AW-1:0];
            cnt_ff  <= cnt_ff + KW'(1);
         end
         psfe_pkg::ST_F_DIVCHK: begin
            if (part_ff == '0) begin
               rem_ff <= dvd_ff;
               pow_ff <= pow_ff + PWW'(1);
            end else begin
               divs_ff <= sat_mul(divs_ff, pow_ff + PWW'(1));
               pow_ff  <= '0;
               idx_ff  <= idx_ff + TW'(1);
            end
         end
         psfe_pkg::ST_F_PUSH: begin
            if (!has_pend_ff || out_free) begin
               pend_ff <= NW'(p_ff);
               if (has_pend_ff) multi_ff <= 1'b1;
            end
         end
         psfe_pkg::ST_FIN_PUSH: begin
            if (rem_ff != NW'(1) && (!has_pend_ff || out_free)) begin
               pend_ff <= rem_ff;
               divs_ff <= sat_mul(divs_ff, PWW'(2));
               if (has_pend_ff) multi_ff <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, o_beyond_ff, o_divs_ff, o_prime_ff, o_factor_ff};
   assign rsp_tuser  = o_fv_ff;
   assign rsp_tlast  = o_last_ff;

endmodule
`default_nettype wire

// ----- rtl/psfe_checker.sv -----
`default_nettype none
module psfe_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [psfe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            rsp_tlast
);

   // Only the final item of a query may lack a factor.
   a_nofactor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("item without factor is not the final item");

   // Summary fields are zero on all but the final item.
   a_mid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[54:40] == 15'd0)
      else $error("summary fields set on a non-final item");

   // A prime has exactly two divisors.
   a_prime_divs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> rsp_tlast && rsp_tuser && rsp_tdata[53:41] == 13'd2)
      else $error("prime reported with wrong divisor count");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

endmodule

bind prime_sieve_factor_engine psfe_checker u_psfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ----- tb/tb_prime_sieve_factor_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_prime_sieve_factor_engine;

   localparam int  SIEVE_N   = psfe_pkg::SIEVE_SIZE_DEF;
   localparam int  SLOTS_N   = psfe_pkg::PRIME_SLOTS_DEF;
   localparam int  MAX_FACS  = 40;
   localparam longint CYCLE_LIMIT = 40000000;
   localparam logic [psfe_pkg::NUM_W-1:0] NUM_ALL = {psfe_pkg::NUM_W{1'b1}};

   typedef struct packed {
      logic [psfe_pkg::NUM_W-1:0] factor;
      logic                       factor_valid;
      logic                       last;
      logic                       is_prime;
      logic [psfe_pkg::DIV_W-1:0] divisor_count;
      logic                       beyond_range;
   } factor_item_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [psfe_pkg::NUM_W-1:0]      req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [psfe_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we;
   logic [psfe_pkg::LIMIT_W-1:0]    csr_wdata;

   // Model state of the sieve and the prime list.
   bit                           sieve_bits [0:SIEVE_N-1];
   logic [psfe_pkg::LIMIT_W-1:0] prime_tab [0:SLOTS_N-1];
   int unsigned                  prime_cnt;
   bit                           sieve_built;
   logic [psfe_pkg::LIMIT_W-1:0] limit_reg;

   factor_item_type  factor_q [$];
   int               fail_cnt = 0;
   longint           cycle_cnt = 0;
   int               burst_left;

   prime_sieve_factor_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic build_sieve();
      int unsigned lim;
      int unsigned top;
      longint unsigned j;
      lim = limit_reg;
      if (lim < 2) lim = 2;
      if (lim > SIEVE_N - 2) lim = SIEVE_N - 2;
      top = lim + 1;
      for (int i = 0; i < SIEVE_N; i++) sieve_bits[i] = 1'b1;
      sieve_bits[0] = 1'b0;
      sieve_bits[1] = 1'b0;
      prime_cnt = 0;
      for (int unsigned i = 2; i <= top; i++) begin
         if (sieve_bits[i]) begin
            for (j = longint'(i) * i; j <= top; j += i) sieve_bits[j] = 1'b0;
            if (prime_cnt < SLOTS_N) begin
               prime_tab[prime_cnt] = i[psfe_pkg::LIMIT_W-1:0];
               prime_cnt++;
            end
         end
      end
      sieve_built = 1'b1;
   endtask

   function automatic int unsigned sat_mul(int unsigned a, int unsigned b);
      longint unsigned p;
      p = longint'(a) * b;
      return (p > psfe_pkg::DIV_MAX) ? psfe_pkg::DIV_MAX : int'(p);
   endfunction

   // Appends one expected item at the tail of the queue.
   task automatic expect_item(factor_item_type it);
      factor_q.insert(factor_q.size(), it);
   endtask

   // Trial division over the model's prime list; queues the expected items.
   task automatic predict_factors(logic [psfe_pkg::NUM_W-1:0] num);
      longint unsigned n;
      longint unsigned rem;
      longint unsigned p;
      longint unsigned facs [MAX_FACS];
      int              cnt;
      int unsigned     idx;
      int unsigned     divs;
      int unsigned     power;
      bit              beyond;
      factor_item_type it;
      n = num;
      rem = n;
      cnt = 0;
      idx = 0;
      divs = 1;
      beyond = 1'b0;
      if (!sieve_built) build_sieve();
      if (n <= 1) begin
         it = '0;
         it.last = 1'b1;
         it.divisor_count = (n == 0) ? '0 : psfe_pkg::DIV_W'(1);
         expect_item(it);
         return;
      end
      forever begin
         power = 0;
         if (idx >= prime_cnt) begin
            beyond = 1'b1;
            break;
         end
         p = prime_tab[idx];
         if (p * p > rem) break;
         while (rem % p == 0 && cnt < MAX_FACS) begin
            rem = rem / p;
            facs[cnt] = p;
            cnt++;
            power++;
         end
         divs = sat_mul(divs, power + 1);
         idx++;
      end
      if (beyond) begin
         p = (idx > 0) ? longint'(prime_tab[idx-1]) : 0;
         if (rem == 1 || (idx > 0 && (p + 1) * (p + 1) > rem && rem < 4)) beyond = 1'b0;
      end
      if (rem != 1 && cnt < MAX_FACS) begin
         facs[cnt] = rem;
         cnt++;
         divs = sat_mul(divs, 2);
      end
      for (int k = 0; k < cnt; k++) begin
         it.factor        = facs[k][psfe_pkg::NUM_W-1:0];
         it.factor_valid  = 1'b1;
         it.last          = (k == cnt - 1);
         it.is_prime      = (k == cnt - 1) && (cnt == 1);
         it.divisor_count = (k == cnt - 1) ? divs[psfe_pkg::DIV_W-1:0] : '0;
         it.beyond_range  = (k == cnt - 1) && beyond;
         expect_item(it);
      end
   endtask

   // Sends one number; the sender runs in bursts with random gaps between them.
   task automatic send_number(logic [psfe_pkg::NUM_W-1:0] num);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(8, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= num;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_factors(num);
   endtask

   // Lets the block drain, then writes the limit while it is idle.
   task automatic write_limit(logic [psfe_pkg::LIMIT_W-1:0] lim);
      req_tvalid <= 1'b0;
      while (factor_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_reg   = lim;
      sieve_built = 1'b0;
      burst_left  = 0;
   endtask

   function automatic logic [psfe_pkg::NUM_W-1:0] rand_number();
      logic [psfe_pkg::NUM_W-1:0] v;
      int unsigned                sel;
      sel = $urandom_range(9, 0);
      if (sel < 4) begin
         v = {8'($urandom_range(255, 0)), $urandom()};
      end else if (sel < 7) begin
         v = psfe_pkg::NUM_W'(1);
         repeat ($urandom_range(8, 1)) begin
            if (v < 40'd4000000000) v = v * psfe_pkg::NUM_W'($urandom_range(60, 2));
         end
      end else if (sel < 9) begin
         v = psfe_pkg::NUM_W'($urandom_range(2000, 0));
      end else begin
         v = NUM_ALL - psfe_pkg::NUM_W'($urandom_range(3, 0));
      end
      return v;
   endfunction

   task automatic test_tiny_limit();
      write_limit('0);
      send_number(0);
      send_number(1);
      send_number(2);
      send_number(3);
      send_number(4);
      send_number(5);
      send_number(12);
      send_number(25);
      send_number(49);
      send_number(NUM_ALL);
      send_number(40'h80_0000_0000);
      send_number(40'd847288609443);
      send_number(40'h55_5555_5555);
      send_number(40'hAA_AAAA_AAAA);
      repeat (20) send_number(rand_number());
   endtask

   task automatic test_small_limit();
      write_limit(20'd30);
      send_number(961);
      send_number(1021);
      send_number(29 * 31);
      send_number(40'd4294967296);
      send_number(40'd720720);
      repeat (20) send_number(rand_number());
   endtask

   task automatic test_mid_limit();
      write_limit(20'd1000);
      send_number(40'd997 * 991);
      send_number(40'd1009 * 1013);
      send_number(40'd963761198400);
      repeat (25) send_number(rand_number());
   endtask

   task automatic test_low_limit();
      write_limit(20'd2);
      send_number(9);
      send_number(35);
      send_number(rand_number());
   endtask

   // Top register value; the effective limit saturates just below it.
   task automatic test_top_limit();
      write_limit(20'hFFFFF);
      send_number(40'd999983);
      send_number(40'd997 * 991);
      send_number(NUM_ALL);
      send_number(1);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      burst_left  = 0;
      sieve_built = 1'b0;
      limit_reg   = psfe_pkg::LIMIT_RESET;
      prime_cnt   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tiny_limit();
      test_small_limit();
      test_mid_limit();
      test_low_limit();
      test_top_limit();
      req_tvalid <= 1'b0;
      while (factor_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("[prime_sieve_factor_engine] OK");
      end else begin
         $display("[prime_sieve_factor_engine] ERROR");
      end
      $finish;
   end

   // The receiver switches between always ready, random and mostly stalled.
   int unsigned stall_mode = 0;
   int unsigned stall_span = 0;

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(2, 0);
         stall_span <= $urandom_range(80, 10);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(1, 0));
         end
         default: begin
            rsp_tready <= ($urandom_range(3, 0) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      factor_item_type want;
      factor_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.factor        = rsp_tdata[psfe_pkg::NUM_W-1:0];
         got.is_prime      = rsp_tdata[psfe_pkg::NUM_W];
         got.divisor_count = rsp_tdata[psfe_pkg::NUM_W+psfe_pkg::DIV_W:psfe_pkg::NUM_W+1];
         got.beyond_range  = rsp_tdata[psfe_pkg::NUM_W+psfe_pkg::DIV_W+1];
         got.factor_valid  = rsp_tuser;
         got.last          = rsp_tlast;
         if (factor_q.size() == 0) begin
            $display("%0t: unexpected item, actual %p", $realtime, got);
            fail_cnt++;
         end else begin
            want = factor_q.pop_front();
            if (got !== want || rsp_tdata[psfe_pkg::RSP_DATA_W-1] !== 1'b0) begin
               $display("%0t: mismatch, expected %p, actual %p",
                        $realtime, want, got);
               fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[prime_sieve_factor_engine] ERROR");
         $finish;
      end
   end

endmodule
`default_nettype wire
